>>> rtl/core/vt_pkg.sv
// ----------------------------------------------------------------------------
// vt_pkg
// Shared types and constants of the 2-D vertex transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vt_pkg;

  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 12;
  // Integer bits of a coefficient, sign included (Q4.x format).
  localparam int unsigned COEF_INT_BITS      = 4;

  localparam int unsigned MODE_W    = 4;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE   = 4'd0,
    MODE_SCALE       = 4'd1,
    MODE_ROTATE      = 4'd2,
    MODE_REFL_X      = 4'd3,
    MODE_REFL_Y      = 4'd4,
    MODE_REFL_DIAG   = 4'd5,
    MODE_REFL_ORIGIN = 4'd6,
    MODE_SHEAR_X     = 4'd7,
    MODE_SHEAR_Y     = 4'd8
  } vt_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_OFFSET_Y = 3'd2,
    REG_COEF_A   = 3'd3,
    REG_COEF_B   = 3'd4,
    REG_CENTER_X = 3'd5,
    REG_CENTER_Y = 3'd6
  } vt_reg_e;

  // Control that travels with each beat between pipeline stages.
  typedef struct packed {
    logic valid;
    logic last;
    logic fix;   // value is fixed point and must be rounded
  } vt_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/vt_stream_if.sv
// ----------------------------------------------------------------------------
// vt_stream_if
// Valid/ready channels carrying input vertices and transformed vertices.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt_in_if #(
  parameter int unsigned W = vt_pkg::COORD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_x;
  logic signed [W-1:0] in_y;
  logic                last_vertex;

  modport source (output valid, in_x, in_y, last_vertex, input ready);
  modport sink   (input valid, in_x, in_y, last_vertex, output ready);
endinterface

interface vt_out_if #(
  parameter int unsigned W = vt_pkg::COORD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic                out_last;
  logic                saturated;

  modport source (output valid, out_x, out_y, out_last, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_last, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/core/vt_front.sv
// ----------------------------------------------------------------------------
// vt_front
// First stage: picks the base value and multiplier operands for each lane.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_front #(
  parameter int unsigned COORD_BITS     = vt_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = vt_pkg::COEF_FRAC_BITS_DEF,
  localparam int unsigned COEF_BITS = COEF_FRAC_BITS + vt_pkg::COEF_INT_BITS,
  localparam int unsigned WB = (COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS,
  localparam int unsigned WA = COORD_BITS + 2,
  localparam int unsigned WS = WA + WB + 2
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [COORD_BITS-1:0] in_x_i,
  input  wire  signed [COORD_BITS-1:0] in_y_i,
  input  wire                          in_last_i,
  input  wire  [vt_pkg::MODE_W-1:0]    mode_i,
  input  wire  signed [COORD_BITS-1:0] offset_x_i,
  input  wire  signed [COORD_BITS-1:0] offset_y_i,
  input  wire  signed [COEF_BITS-1:0]  coef_a_i,
  input  wire  signed [COEF_BITS-1:0]  coef_b_i,
  input  wire  signed [COORD_BITS-1:0] center_x_i,
  input  wire  signed [COORD_BITS-1:0] center_y_i,
  output vt_pkg::vt_ctrl_t             ctrl_o,
  input  wire                          ready_i,
  output logic signed [WS-1:0]         base_x_o,
  output logic signed [WS-1:0]         base_y_o,
  output logic signed [WA-1:0]         ax1_o,
  output logic signed [WB-1:0]         bx1_o,
  output logic signed [WA-1:0]         ax2_o,
  output logic signed [WB-1:0]         bx2_o,
  output logic signed [WA-1:0]         ay1_o,
  output logic signed [WB-1:0]         by1_o,
  output logic signed [WA-1:0]         ay2_o,
  output logic signed [WB-1:0]         by2_o
);

  localparam logic signed [WS-1:0] HALF = WS'(1) << (COEF_FRAC_BITS - 1);

  logic valid_q, last_q, fix_q, fix_d, load;
  logic signed [WS-1:0] base_x_q, base_y_q, base_x_d, base_y_d;
  logic signed [WA-1:0] ax1_q, ax2_q, ay1_q, ay2_q, ax1_d, ax2_d, ay1_d, ay2_d;
  logic signed [WB-1:0] bx1_q, bx2_q, by1_q, by2_q, bx1_d, bx2_d, by1_d, by2_d;

  logic signed [WA-1:0] x_e, y_e, dx, dy;
  logic signed [WS-1:0] fbase_x, fbase_y;
  logic signed [WB-1:0] ca_e, cb_e, ox_e, oy_e;

  assign in_ready_o = !valid_q || ready_i;
  assign load       = in_valid_i && in_ready_o;

  assign x_e  = WA'(in_x_i);
  assign y_e  = WA'(in_y_i);
  assign dx   = x_e - WA'(center_x_i);
  assign dy   = y_e - WA'(center_y_i);
  assign ca_e = WB'(coef_a_i);
  assign cb_e = WB'(coef_b_i);
  assign ox_e = WB'(offset_x_i);
  assign oy_e = WB'(offset_y_i);
  // Fixed-point base: the center scaled up, with the rounding half folded in.
  assign fbase_x = (WS'(center_x_i) <<< COEF_FRAC_BITS) + HALF;
  assign fbase_y = (WS'(center_y_i) <<< COEF_FRAC_BITS) + HALF;

  always_comb begin
    fix_d    = 1'b0;
    base_x_d = WS'(in_x_i);
    base_y_d = WS'(in_y_i);
    ax1_d = '0; bx1_d = '0; ax2_d = '0; bx2_d = '0;
    ay1_d = '0; by1_d = '0; ay2_d = '0; by2_d = '0;
    case (mode_i)
      vt_pkg::MODE_TRANSLATE: begin
        base_x_d = WS'(in_x_i) + WS'(offset_x_i);
        base_y_d = WS'(in_y_i) + WS'(offset_y_i);
      end
      vt_pkg::MODE_SCALE: begin
        fix_d    = 1'b1;
        base_x_d = fbase_x;
        base_y_d = fbase_y;
        ax1_d = dx; bx1_d = ca_e;
        ay1_d = dy; by1_d = cb_e;
      end
      vt_pkg::MODE_ROTATE: begin
        fix_d    = 1'b1;
        base_x_d = fbase_x;
        base_y_d = fbase_y;
        ax1_d = dx;  bx1_d = ca_e;
        ax2_d = -dy; bx2_d = cb_e;
        ay1_d = dx;  by1_d = cb_e;
        ay2_d = dy;  by2_d = ca_e;
      end
      vt_pkg::MODE_REFL_X:      base_y_d = -WS'(in_y_i);
      vt_pkg::MODE_REFL_Y:      base_x_d = -WS'(in_x_i);
      vt_pkg::MODE_REFL_DIAG: begin
        base_x_d = WS'(in_y_i);
        base_y_d = WS'(in_x_i);
      end
      vt_pkg::MODE_REFL_ORIGIN: begin
        base_x_d = -WS'(in_x_i);
        base_y_d = -WS'(in_y_i);
      end
      vt_pkg::MODE_SHEAR_X: begin
        ax1_d = y_e; bx1_d = ox_e;
      end
      vt_pkg::MODE_SHEAR_Y: begin
        ay1_d = x_e; by1_d = oy_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q   <= in_last_i;
      fix_q    <= fix_d;
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      ax1_q <= ax1_d; bx1_q <= bx1_d; ax2_q <= ax2_d; bx2_q <= bx2_d;
      ay1_q <= ay1_d; by1_q <= by1_d; ay2_q <= ay2_d; by2_q <= by2_d;
    end
  end

  assign ctrl_o = '{valid: valid_q, last: last_q, fix: fix_q};
  assign base_x_o = base_x_q;
  assign base_y_o = base_y_q;
  assign ax1_o = ax1_q; assign bx1_o = bx1_q;
  assign ax2_o = ax2_q; assign bx2_o = bx2_q;
  assign ay1_o = ay1_q; assign by1_o = by1_q;
  assign ay2_o = ay2_q; assign by2_o = by2_q;

endmodule

`default_nettype wire

>>> rtl/core/vt_mac.sv
// ----------------------------------------------------------------------------
// vt_mac
// Multiply stage followed by an add-and-round stage for both lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_mac #(
  parameter int unsigned COORD_BITS     = vt_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = vt_pkg::COEF_FRAC_BITS_DEF,
  localparam int unsigned COEF_BITS = COEF_FRAC_BITS + vt_pkg::COEF_INT_BITS,
  localparam int unsigned WB = (COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS,
  localparam int unsigned WA = COORD_BITS + 2,
  localparam int unsigned WP = WA + WB,
  localparam int unsigned WS = WP + 2
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire vt_pkg::vt_ctrl_t    ctrl_i,
  output logic                     ready_o,
  input  wire  signed [WS-1:0]     base_x_i,
  input  wire  signed [WS-1:0]     base_y_i,
  input  wire  signed [WA-1:0]     ax1_i,
  input  wire  signed [WB-1:0]     bx1_i,
  input  wire  signed [WA-1:0]     ax2_i,
  input  wire  signed [WB-1:0]     bx2_i,
  input  wire  signed [WA-1:0]     ay1_i,
  input  wire  signed [WB-1:0]     by1_i,
  input  wire  signed [WA-1:0]     ay2_i,
  input  wire  signed [WB-1:0]     by2_i,
  output vt_pkg::vt_ctrl_t         ctrl_o,
  input  wire                      ready_i,
  output logic signed [WS-1:0]     val_x_o,
  output logic signed [WS-1:0]     val_y_o
);

  // Product stage registers.
  logic                 pv_q, plast_q, pfix_q, p_en, p_load;
  logic signed [WS-1:0] pbase_x_q, pbase_y_q;
  logic signed [WP-1:0] px1_q, px2_q, py1_q, py2_q, px1_d, px2_d, py1_d, py2_d;

  // Sum stage registers.
  logic                 sv_q, slast_q, s_en, s_load;
  logic signed [WS-1:0] sum_x, sum_y, val_x_d, val_y_d, val_x_q, val_y_q;

  assign s_en    = !sv_q || ready_i;
  assign p_en    = !pv_q || s_en;
  assign ready_o = p_en;
  assign p_load  = ctrl_i.valid && p_en;
  assign s_load  = pv_q && s_en;

  assign px1_d = WP'(ax1_i) * WP'(bx1_i);
  assign px2_d = WP'(ax2_i) * WP'(bx2_i);
  assign py1_d = WP'(ay1_i) * WP'(by1_i);
  assign py2_d = WP'(ay2_i) * WP'(by2_i);

  assign sum_x = pbase_x_q + WS'(px1_q) + WS'(px2_q);
  assign sum_y = pbase_y_q + WS'(py1_q) + WS'(py2_q);
  // The half was added in the base, so a floor shift rounds half up.
  assign val_x_d = pfix_q ? (sum_x >>> COEF_FRAC_BITS) : sum_x;
  assign val_y_d = pfix_q ? (sum_y >>> COEF_FRAC_BITS) : sum_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (p_en) begin
        pv_q <= ctrl_i.valid;
      end
      if (s_en) begin
        sv_q <= pv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_load) begin
      plast_q   <= ctrl_i.last;
      pfix_q    <= ctrl_i.fix;
      pbase_x_q <= base_x_i;
      pbase_y_q <= base_y_i;
      px1_q     <= px1_d;
      px2_q     <= px2_d;
      py1_q     <= py1_d;
      py2_q     <= py2_d;
    end
    if (s_load) begin
      slast_q <= plast_q;
      val_x_q <= val_x_d;
      val_y_q <= val_y_d;
    end
  end

  assign ctrl_o  = '{valid: sv_q, last: slast_q, fix: 1'b0};
  assign val_x_o = val_x_q;
  assign val_y_o = val_y_q;

endmodule

`default_nettype wire

>>> rtl/core/vt_sat.sv
// ----------------------------------------------------------------------------
// vt_sat
// Output stage: clips both coordinates to range and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_sat #(
  parameter int unsigned COORD_BITS = vt_pkg::COORD_BITS_DEF,
  parameter int unsigned WS         = 2 * vt_pkg::COORD_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire vt_pkg::vt_ctrl_t        ctrl_i,
  output logic                         ready_o,
  input  wire  signed [WS-1:0]         val_x_i,
  input  wire  signed [WS-1:0]         val_y_i,
  output logic                         valid_o,
  input  wire                          ready_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         out_last_o,
  output logic                         sat_o
);

  localparam logic signed [WS-1:0] HI = WS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic signed [WS-1:0] LO = -HI - WS'(1);
  localparam logic signed [COORD_BITS-1:0] HI_C = HI[COORD_BITS-1:0];
  localparam logic signed [COORD_BITS-1:0] LO_C = LO[COORD_BITS-1:0];

  logic valid_q, last_q, sat_q, sat_d, load;
  logic signed [COORD_BITS-1:0] x_q, y_q, x_d, y_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = ctrl_i.valid && ready_o;

  always_comb begin
    sat_d = 1'b0;
    x_d   = val_x_i[COORD_BITS-1:0];
    y_d   = val_y_i[COORD_BITS-1:0];
    if (val_x_i > HI) begin
      x_d = HI_C; sat_d = 1'b1;
    end else if (val_x_i < LO) begin
      x_d = LO_C; sat_d = 1'b1;
    end
    if (val_y_i > HI) begin
      y_d = HI_C; sat_d = 1'b1;
    end else if (val_y_i < LO) begin
      y_d = LO_C; sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= x_d;
      y_q    <= y_d;
      last_q <= ctrl_i.last;
      sat_q  <= sat_d;
    end
  end

  assign valid_o    = valid_q;
  assign out_x_o    = x_q;
  assign out_y_o    = y_q;
  assign out_last_o = last_q;
  assign sat_o      = sat_q;

  // A raised flag means at least one coordinate sits at a range limit.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && sat_q |-> (x_q == HI_C || x_q == LO_C || y_q == HI_C || y_q == LO_C))
    else $error("saturated beat has no coordinate at a limit");

  // In-range values pass unchanged and leave the flag low.
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && val_x_i <= HI && val_x_i >= LO && val_y_i <= HI && val_y_i >= LO
    |=> !sat_q && x_q == $past(val_x_i[COORD_BITS-1:0])
        && y_q == $past(val_y_i[COORD_BITS-1:0]))
    else $error("in-range value altered or flagged");

  // An overflowing x clips to the top of the range and raises the flag.
  a_clip_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && val_x_i > HI |=> sat_q && x_q == HI_C)
    else $error("overflowing x not clipped");

endmodule

`default_nettype wire

>>> rtl/core/vertex_2d_transform.sv
// An accepted input beat passes through the register stages below to its result beat on the output.
// Throughput: one vertex per cycle while the output is not stalled; operand select, multiply,
// add/round and clip are each one register stage, and a stall holds each full stage whose next one is full.
// Reset clears all stage valid bits and sets the registers to their defaults:
// translate mode, zero offsets and center, both coefficients 1.0.
// ----------------------------------------------------------------------------
// vertex_2d_transform
// Streaming 2-D affine transform of signed vertices with rounding and clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_2d_transform #(
  parameter int unsigned COORD_BITS     = vt_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = vt_pkg::COEF_FRAC_BITS_DEF,
  localparam int unsigned COEF_BITS = COEF_FRAC_BITS + vt_pkg::COEF_INT_BITS,
  localparam int unsigned CFG_W = (COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  vt_in_if.sink                         in_i,
  vt_out_if.source                      out_o,
  input  wire                           cfg_we_i,
  input  wire  [vt_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_W-1:0]              cfg_data_i
);

  localparam int unsigned WB = CFG_W;
  localparam int unsigned WA = COORD_BITS + 2;
  localparam int unsigned WS = WA + WB + 2;

  logic [vt_pkg::MODE_W-1:0]    mode_q;
  logic signed [COORD_BITS-1:0] offset_x_q, offset_y_q, center_x_q, center_y_q;
  logic signed [COEF_BITS-1:0]  coef_a_q, coef_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= vt_pkg::MODE_TRANSLATE;
      offset_x_q <= '0;
      offset_y_q <= '0;
      coef_a_q   <= COEF_BITS'(1) << COEF_FRAC_BITS;
      coef_b_q   <= COEF_BITS'(1) << COEF_FRAC_BITS;
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vt_pkg::REG_MODE:     mode_q     <= cfg_data_i[vt_pkg::MODE_W-1:0];
        vt_pkg::REG_OFFSET_X: offset_x_q <= cfg_data_i[COORD_BITS-1:0];
        vt_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data_i[COORD_BITS-1:0];
        vt_pkg::REG_COEF_A:   coef_a_q   <= cfg_data_i[COEF_BITS-1:0];
        vt_pkg::REG_COEF_B:   coef_b_q   <= cfg_data_i[COEF_BITS-1:0];
        vt_pkg::REG_CENTER_X: center_x_q <= cfg_data_i[COORD_BITS-1:0];
        vt_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  vt_pkg::vt_ctrl_t     f_ctrl, m_ctrl;
  logic                 m_ready, s_ready;
  logic signed [WS-1:0] base_x, base_y, val_x, val_y;
  logic signed [WA-1:0] ax1, ax2, ay1, ay2;
  logic signed [WB-1:0] bx1, bx2, by1, by2;

  vt_front #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_x_i     (in_i.in_x),
    .in_y_i     (in_i.in_y),
    .in_last_i  (in_i.last_vertex),
    .mode_i     (mode_q),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .coef_a_i   (coef_a_q),
    .coef_b_i   (coef_b_q),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .ctrl_o     (f_ctrl),
    .ready_i    (m_ready),
    .base_x_o   (base_x),
    .base_y_o   (base_y),
    .ax1_o (ax1), .bx1_o (bx1), .ax2_o (ax2), .bx2_o (bx2),
    .ay1_o (ay1), .by1_o (by1), .ay2_o (ay2), .by2_o (by2)
  );

  vt_mac #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (f_ctrl),
    .ready_o  (m_ready),
    .base_x_i (base_x),
    .base_y_i (base_y),
    .ax1_i (ax1), .bx1_i (bx1), .ax2_i (ax2), .bx2_i (bx2),
    .ay1_i (ay1), .by1_i (by1), .ay2_i (ay2), .by2_i (by2),
    .ctrl_o   (m_ctrl),
    .ready_i  (s_ready),
    .val_x_o  (val_x),
    .val_y_o  (val_y)
  );

  vt_sat #(
    .COORD_BITS (COORD_BITS),
    .WS         (WS)
  ) u_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (m_ctrl),
    .ready_o    (s_ready),
    .val_x_i    (val_x),
    .val_y_i    (val_y),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .out_x_o    (out_o.out_x),
    .out_y_o    (out_o.out_y),
    .out_last_o (out_o.out_last),
    .sat_o      (out_o.saturated)
  );

endmodule

`default_nettype wire
